FILE: sv/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// shared constants and controller/datapath interface types for the factorizer
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int POS_W              = 5;
  localparam int MAX_RESULTS        = 30;
  localparam int FIRST_EVEN_FACTOR  = 2;
  localparam int FIRST_ODD_DIVISOR  = 3;

  typedef logic [POS_W-1:0] pos_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // take a new number, reset count and divisor
    logic emit_none;   // result for zero or one
    logic emit_two;    // emit factor two, halve the remainder
    logic emit_div;    // emit trial divisor, remainder takes the quotient
    logic emit_final;  // emit the leftover remainder as last factor
    logic div_start;   // start remainder / divisor
    logic step;        // next odd divisor
  } tdf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic rem_lt2;     // remainder is zero or one
    logic rem_odd;
    logic sq_le_rem;   // divisor squared fits under remainder
    logic div_done;
    logic div_zero;    // division left no remainder
    logic last_two;    // an emitted two would close the item
    logic last_div;    // an emitted divisor would close the item
    logic out_free;    // output register can take a result this cycle
  } tdf_sts_t;

endpackage

FILE: sv/tdf_div.sv
// ----------------------------------------------------------------------------
// tdf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdf_div #(
  parameter int NW = 31,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quot,
  output logic          rmd_zero,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW:0]   p_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0] p_sh;
  logic        ge;
  logic [DW:0] p_nxt;

  always_comb begin
    p_sh  = {p_r[DW-1:0], q_r[NW-1]};
    ge    = p_sh >= {1'b0, divisor};
    p_nxt = ge ? (p_sh - {1'b0, divisor}) : p_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      p_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[NW-2:0], ge};
      p_r <= p_nxt;
    end
  end

  assign quot     = q_r;
  assign rmd_zero = (p_r == '0);
  assign done     = done_r;

endmodule

FILE: sv/tdf_dpath.sv
// ----------------------------------------------------------------------------
// tdf_dpath
// remainder, divisor, square and count registers, divider and result register
// ----------------------------------------------------------------------------
module tdf_dpath
  import tdf_pkg::*;
#(
  parameter int NW = 31,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tdf_cmd_t      cmd,
  output tdf_sts_t      sts,
  input  logic [NW-1:0] number,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [NW-1:0] out_factor,
  output pos_t          out_position,
  output logic          out_has_factor,
  output logic          out_last_factor
);

  localparam int SW = 2 * DW;

  logic [NW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [SW-1:0] sq_r;
  pos_t          cnt_r;

  logic          out_valid_r;
  logic [NW-1:0] factor_r;
  pos_t          position_r;
  logic          has_r;
  logic          last_r;

  logic [NW-1:0] quot;
  logic          rmd_zero;
  logic          div_done;
  logic          cnt_max;

  tdf_div #(.NW(NW), .DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rem_r),
    .divisor  (d_r),
    .quot     (quot),
    .rmd_zero (rmd_zero),
    .done     (div_done)
  );

  assign cnt_max = (cnt_r == POS_W'(MAX_RESULTS - 1));

  always_comb begin
    sts.rem_lt2   = rem_r < NW'(2);
    sts.rem_odd   = rem_r[0];
    sts.sq_le_rem = sq_r <= SW'(rem_r);
    sts.div_done  = div_done;
    sts.div_zero  = rmd_zero;
    sts.last_two  = ((rem_r >> 1) == NW'(1)) || cnt_max;
    sts.last_div  = (quot == NW'(1)) || cnt_max;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= number;
      cnt_r <= '0;
      d_r   <= DW'(FIRST_ODD_DIVISOR);
      sq_r  <= SW'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
    end else begin
      if (cmd.emit_two) begin
        rem_r <= rem_r >> 1;
        cnt_r <= cnt_r + POS_W'(1);
      end
      if (cmd.emit_div) begin
        rem_r <= quot;
        cnt_r <= cnt_r + POS_W'(1);
      end
      if (cmd.step) begin
        // (d+2)^2 = d^2 + 4d + 4
        d_r  <= d_r + DW'(2);
        sq_r <= sq_r + SW'({d_r, 2'b00}) + SW'(4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_none || cmd.emit_two || cmd.emit_div || cmd.emit_final) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_none) begin
      factor_r   <= '0;
      position_r <= '0;
      has_r      <= 1'b0;
      last_r     <= 1'b1;
    end else if (cmd.emit_two) begin
      factor_r   <= NW'(FIRST_EVEN_FACTOR);
      position_r <= cnt_r + POS_W'(1);
      has_r      <= 1'b1;
      last_r     <= sts.last_two;
    end else if (cmd.emit_div) begin
      factor_r   <= {{(NW-DW){1'b0}}, d_r};
      position_r <= cnt_r + POS_W'(1);
      has_r      <= 1'b1;
      last_r     <= sts.last_div;
    end else if (cmd.emit_final) begin
      factor_r   <= rem_r;
      position_r <= cnt_r + POS_W'(1);
      has_r      <= 1'b1;
      last_r     <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_factor      = factor_r;
  assign out_position    = position_r;
  assign out_has_factor  = has_r;
  assign out_last_factor = last_r;

endmodule

FILE: sv/tdf_ctrl.sv
// ----------------------------------------------------------------------------
// tdf_ctrl
// sequencing state machine for the factorizer
// ----------------------------------------------------------------------------
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tdf_sts_t sts,
  output tdf_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_TWOS,
    S_CHECK,
    S_DIV,
    S_DEMIT,
    S_RESTART,
    S_STEP,
    S_FINAL
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (!sts.rem_lt2) begin
          state_nxt = S_TWOS;
        end else if (sts.out_free) begin
          cmd.emit_none = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TWOS: begin
        if (sts.rem_odd) begin
          state_nxt = S_CHECK;
        end else if (sts.out_free) begin
          cmd.emit_two = 1'b1;
          if (sts.last_two) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CHECK: begin
        if (sts.sq_le_rem) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.div_zero ? S_DEMIT : S_STEP;
        end
      end
      S_DEMIT: begin
        if (sts.out_free) begin
          cmd.emit_div = 1'b1;
          state_nxt    = sts.last_div ? S_IDLE : S_RESTART;
        end
      end
      S_RESTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTH
  a_emit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_none, cmd.emit_two, cmd.emit_div, cmd.emit_final}))
    else $error("more than one result emitted in a cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_none || cmd.emit_two || cmd.emit_div || cmd.emit_final) |-> sts.out_free)
    else $error("result emitted while output register is held");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_stall)
    else $error("request taken but block did not go busy");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == S_DIV) && !sts.div_done)
    else $error("division start not followed by a wait for the divider");
`endif

endmodule

FILE: sv/trial_division_factorizer.sv
// a request of 0 or 1 gets its result from S_START once the output register is free
// twos are emitted in S_TWOS; each odd divisor runs S_CHECK, S_DIV, then S_STEP
// the shared bit-serial divider (one quotient bit a cycle) sets the pace
// worst case for 31 bits is about 23000 odd divisors
// one request at a time; in_stall is high from acceptance until the last result is loaded
// rst_n is synchronous; it clears the state machine, divider control and result valid
// ----------------------------------------------------------------------------
// trial_division_factorizer
// prime factorization by trial division, factors emitted in ascending order
// ----------------------------------------------------------------------------
module trial_division_factorizer
  import tdf_pkg::*;
#(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [NUMBER_WIDTH-1:0] out_factor,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_has_factor,
  output logic                    out_last_factor
);

  // trial divisors stay at or below the square root of the remainder,
  // plus room for the step that fails the square test
  localparam int DIV_W = (NUMBER_WIDTH + 1) / 2 + 1;

  tdf_cmd_t cmd;
  tdf_sts_t sts;

  // controller: walks twos, odd divisors and the final remainder
  tdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: remainder, divisor with its running square, divider, result register
  tdf_dpath #(
    .NW (NUMBER_WIDTH),
    .DW (DIV_W)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .number          (in_number),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_factor      (out_factor),
    .out_position    (out_position),
    .out_has_factor  (out_has_factor),
    .out_last_factor (out_last_factor)
  );

endmodule
